// ===== rtl/bse_pkg.sv =====
// shared types and constants for the burning ship escape-time unit
`default_nettype none

package bse_pkg;

	// fixed point and field widths
	localparam int COORD_BITS = 11;
	localparam int WORD_BITS  = 32;
	localparam int FRAC_BITS  = 28;
	localparam int ITER_BITS  = 16;
	localparam int STEP_BITS  = WORD_BITS - 1;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP        = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_REAL_ORIGIN = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAG_ORIGIN = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_ITER_LIMIT  = CFG_IDX_BITS'(3);

	// configuration reset values
	localparam logic [STEP_BITS-1:0]        STEP_RESET   = STEP_BITS'(894784);
	localparam logic signed [WORD_BITS-1:0] ORIGIN_RESET = WORD_BITS'(-536870912);
	localparam logic [ITER_BITS-1:0]        LIMIT_RESET  = ITER_BITS'(64);

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// input request
	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
	} pixel_t;

	// result request
	typedef struct packed {
		logic [COORD_BITS-1:0] out_x;
		logic [COORD_BITS-1:0] out_y;
		logic [ITER_BITS-1:0]  iteration_count;
	} result_t;

	// plane mapping registers seen by the front
	typedef struct packed {
		logic [STEP_BITS-1:0]        step;
		logic signed [WORD_BITS-1:0] real_origin;
		logic signed [WORD_BITS-1:0] imag_origin;
	} plane_cfg_t;

	// classified point handed from front to back
	typedef struct packed {
		logic [COORD_BITS-1:0]       x;
		logic [COORD_BITS-1:0]       y;
		logic signed [WORD_BITS-1:0] cr;
		logic signed [WORD_BITS-1:0] ci;
	} point_t;

	// queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

// ===== rtl/bse_front.sv =====
// front end: maps a pixel to its plane point c and pushes it to the queue
`default_nettype none

module bse_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   pix_valid,
	output logic                  pix_stall,
	input  bse_pkg::pixel_t       pix,
	input  bse_pkg::plane_cfg_t   plane,
	input  bse_pkg::queue_status_t qstat,
	output logic                  push,
	output bse_pkg::point_t       point
);

	localparam int W        = bse_pkg::WORD_BITS;
	localparam int P_BITS   = bse_pkg::COORD_BITS + bse_pkg::STEP_BITS;
	localparam int SUM_BITS = P_BITS + 2;

	logic                              valid_s1;
	logic [bse_pkg::COORD_BITS-1:0]    x_s1;
	logic [bse_pkg::COORD_BITS-1:0]    y_s1;
	logic [P_BITS-1:0]                 pr_s1;
	logic [P_BITS-1:0]                 pi_s1;
	logic                              take;
	logic signed [SUM_BITS-1:0]        sum_r;
	logic signed [SUM_BITS-1:0]        sum_i;

	// clamp a wide sum into the signed word range
	function automatic logic signed [W-1:0] sat_word(input logic signed [SUM_BITS-1:0] v);
		logic [SUM_BITS-W:0] top;
		top = v[SUM_BITS-1:W-1];
		if (top == '0 || top == '1) begin
			sat_word = v[W-1:0];
		end else if (v[SUM_BITS-1]) begin
			sat_word = {1'b1, {(W-1){1'b0}}};
		end else begin
			sat_word = {1'b0, {(W-1){1'b1}}};
		end
	endfunction

	// stage handshake: stage one holds while the queue is full
	assign push      = valid_s1 && !qstat.full;
	assign pix_stall = valid_s1 && qstat.full;
	assign take      = pix_valid && !pix_stall;

	// stage one: pixel times step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s1  <= pix.pixel_x;
			y_s1  <= pix.pixel_y;
			pr_s1 <= P_BITS'(pix.pixel_x) * P_BITS'(plane.step);
			pi_s1 <= P_BITS'(pix.pixel_y) * P_BITS'(plane.step);
		end
	end

	// stage two: add origin and saturate
	assign sum_r = signed'({2'b00, pr_s1}) + SUM_BITS'(plane.real_origin);
	assign sum_i = signed'({2'b00, pi_s1}) + SUM_BITS'(plane.imag_origin);

	always_comb begin
		point.x  = x_s1;
		point.y  = y_s1;
		point.cr = sat_word(sum_r);
		point.ci = sat_word(sum_i);
	end

endmodule

`default_nettype wire

// ===== rtl/bse_queue.sv =====
// short queue of classified points between front and back
`default_nettype none

module bse_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  bse_pkg::point_t        wr,
	input  wire                    pop,
	output bse_pkg::point_t        rd,
	output bse_pkg::queue_status_t qstat
);

	localparam int PB = bse_pkg::QPTR_BITS;

	bse_pkg::point_t entry_q [bse_pkg::QUEUE_DEPTH];
	logic [PB-1:0]   wptr_q;
	logic [PB-1:0]   rptr_q;
	logic [PB:0]     cnt_q;

	assign qstat.full  = (cnt_q == (PB+1)'(bse_pkg::QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign rd          = entry_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PB'(bse_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PB'(bse_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= wr;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bse_back.sv =====
// back end: iterates the burning ship map and holds the result register
`default_nettype none

module bse_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  bse_pkg::queue_status_t       qstat,
	input  bse_pkg::point_t              rd,
	output logic                         pop,
	input  wire [bse_pkg::ITER_BITS-1:0] limit,
	output logic                         res_valid,
	input  wire                          res_stall,
	output bse_pkg::result_t             res
);

	localparam int W      = bse_pkg::WORD_BITS;
	localparam int F      = bse_pkg::FRAC_BITS;
	localparam int PW     = 2 * W;
	localparam int WIDE   = PW - F + 2;
	localparam logic [PW:0] THRESH = (PW+1)'(1) << (2 * F + 2);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_TEST = 2'd2;

	logic [1:0]                     state_q;
	logic [W-1:0]                   ar_q;
	logic [W-1:0]                   ai_q;
	logic signed [W-1:0]            cr_q;
	logic signed [W-1:0]            ci_q;
	logic [bse_pkg::COORD_BITS-1:0] x_q;
	logic [bse_pkg::COORD_BITS-1:0] y_q;
	logic [bse_pkg::ITER_BITS-1:0]  count_q;
	logic [PW-1:0]                  rr_q;
	logic [PW-1:0]                  ii_q;
	logic [PW-1:0]                  xx_q;
	logic                           res_valid_q;
	bse_pkg::result_t               res_q;

	logic [PW:0]                    mag_sum;
	logic                           done;
	logic                           emit;
	logic signed [WIDE-1:0]         nr;
	logic signed [WIDE-1:0]         ni;

	// magnitude of a signed word, exact for the most negative value
	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		mag = v[W-1] ? (~v + 1'b1) : v;
	endfunction

	// clamp a wide value into the signed word range
	function automatic logic signed [W-1:0] sat_word(input logic signed [WIDE-1:0] v);
		logic [WIDE-W:0] top;
		top = v[WIDE-1:W-1];
		if (top == '0 || top == '1) begin
			sat_word = v[W-1:0];
		end else if (v[WIDE-1]) begin
			sat_word = {1'b1, {(W-1){1'b0}}};
		end else begin
			sat_word = {1'b0, {(W-1){1'b1}}};
		end
	endfunction

	// escape test and next z from the registered products
	assign mag_sum = {1'b0, rr_q} + {1'b0, ii_q};
	assign done    = (mag_sum >= THRESH) || (count_q >= limit);
	assign emit    = (state_q == ST_TEST) && done && (!res_valid_q || !res_stall);
	assign nr      = signed'({2'b00, rr_q[PW-1:F]}) - signed'({2'b00, ii_q[PW-1:F]})
	               + WIDE'(cr_q);
	assign ni      = signed'({1'b0, xx_q[PW-1:F-1]}) + WIDE'(ci_q);
	assign pop     = (state_q == ST_IDLE) && !qstat.empty;

	// iteration sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end else if (!done) begin
						state_q <= ST_MUL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// point and z registers
	always_ff @(posedge clk) begin
		if (pop) begin
			x_q     <= rd.x;
			y_q     <= rd.y;
			cr_q    <= rd.cr;
			ci_q    <= rd.ci;
			ar_q    <= mag(rd.cr);
			ai_q    <= mag(rd.ci);
			count_q <= bse_pkg::ITER_BITS'(1);
		end else if (state_q == ST_TEST && !done) begin
			ar_q    <= mag(sat_word(nr));
			ai_q    <= mag(sat_word(ni));
			count_q <= count_q + 1'b1;
		end
	end

	// shared multipliers: squares and cross product
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			rr_q <= PW'(ar_q) * PW'(ar_q);
			ii_q <= PW'(ai_q) * PW'(ai_q);
			xx_q <= PW'(ar_q) * PW'(ai_q);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.out_x           <= x_q;
			res_q.out_y           <= y_q;
			res_q.iteration_count <= count_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== rtl/burning_ship_escape_time.sv =====
// top level of the burning ship escape-time unit with its register file
`default_nettype none

//  channel  signals                                   moves
//  pix      pix_valid, pix_stall, pix                 pixel request in
//  res      res_valid, res_stall, res                 result request out
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// the front maps a pixel in two stages and writes it into the four-entry
// queue from its stage-one register; it takes one request a cycle while the
// queue has room. the back pops a pixel in its idle state, then spends one
// multiply state and one test state per iteration on its three shared
// multipliers. arst_n clears all control state and loads the register reset
// values. a stalled result holds the back in its last test state; the front
// keeps filling the queue meanwhile.

module burning_ship_escape_time (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             pix_valid,
	output logic                            pix_stall,
	input  bse_pkg::pixel_t                 pix,
	output logic                            res_valid,
	input  wire                             res_stall,
	output bse_pkg::result_t                res,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [bse_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire [bse_pkg::WORD_BITS-1:0]    cfg_data
);

	bse_pkg::plane_cfg_t           plane_q;
	logic [bse_pkg::ITER_BITS-1:0] limit_q;
	bse_pkg::queue_status_t        qstat;
	bse_pkg::point_t               wr_point;
	bse_pkg::point_t               rd_point;
	logic                          push;
	logic                          pop;

	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q.step        <= bse_pkg::STEP_RESET;
			plane_q.real_origin <= bse_pkg::ORIGIN_RESET;
			plane_q.imag_origin <= bse_pkg::ORIGIN_RESET;
			limit_q             <= bse_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bse_pkg::REG_STEP: begin
					plane_q.step <= cfg_data[bse_pkg::STEP_BITS-1:0];
				end
				bse_pkg::REG_REAL_ORIGIN: begin
					plane_q.real_origin <= cfg_data;
				end
				bse_pkg::REG_IMAG_ORIGIN: begin
					plane_q.imag_origin <= cfg_data;
				end
				bse_pkg::REG_ITER_LIMIT: begin
					limit_q <= cfg_data[bse_pkg::ITER_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// pixel to plane mapping
	bse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.plane     (plane_q),
		.qstat     (qstat),
		.push      (push),
		.point     (wr_point)
	);

	// decoupling queue
	bse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr     (wr_point),
		.pop    (pop),
		.rd     (rd_point),
		.qstat  (qstat)
	);

	// iteration engine
	bse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.rd        (rd_point),
		.pop       (pop),
		.limit     (limit_q),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire

// ===== bench/burning_ship_escape_time_tb.sv =====
// self-checking testbench for the burning ship escape-time unit
`timescale 1ns / 1ps

module burning_ship_escape_time_tb;
	import bse_pkg::*;

	localparam int     SETTLE_CYCLES = 8;
	localparam int     LONG_HOLD     = 400;
	localparam int     PIX_MAX       = (1 << COORD_BITS) - 1;
	localparam longint WORD_MAX      = (longint'(1) << (WORD_BITS - 1)) - 1;
	localparam longint WORD_MIN      = -WORD_MAX - 1;
	localparam longint unsigned PRODUCT_SPAN = (longint'(1) << WORD_BITS) - 1;
	localparam logic [64:0] ESCAPE_NORM = 65'd1 << (2 * FRAC_BITS + 2);

	// word constants used by the directed tests
	localparam logic [WORD_BITS-1:0] W_MIN = 32'h8000_0000;
	localparam logic [WORD_BITS-1:0] W_MAX = 32'h7FFF_FFFF;
	localparam logic [WORD_BITS-1:0] W_TWO = 32'h2000_0000;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    pix_valid = 1'b0;
	logic                    pix_stall;
	pixel_t                  pix       = '0;
	logic                    res_valid;
	logic                    res_stall = 1'b0;
	result_t                 res;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [WORD_BITS-1:0]    cfg_data  = '0;

	burning_ship_escape_time uut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// local copy of the plane mapping and limit registers
	logic [STEP_BITS-1:0]        plane_step = STEP_RESET;
	logic signed [WORD_BITS-1:0] plane_re   = ORIGIN_RESET;
	logic signed [WORD_BITS-1:0] plane_im   = ORIGIN_RESET;
	logic [ITER_BITS-1:0]        iter_limit = LIMIT_RESET;

	result_t pending_results[$];
	int      mismatches    = 0;
	int      results_seen  = 0;
	int      pixels_sent   = 0;
	int      config_writes = 0;
	bit      tx_idle       = 1'b1;
	bit      rx_idle       = 1'b1;
	int      hold_request  = 0;

	always #6 clk = ~clk;

	// clamp to the signed word range
	function automatic longint clamp_word(input longint v);
		if (v > WORD_MAX) return WORD_MAX;
		if (v < WORD_MIN) return WORD_MIN;
		return v;
	endfunction

	function automatic logic [63:0] magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// pixel index to plane coordinate, exact product then saturation
	function automatic longint plane_point(input logic [COORD_BITS-1:0] idx,
			input logic signed [WORD_BITS-1:0] origin);
		longint unsigned prod;
		prod = longint'(idx) * longint'(plane_step);
		if (prod > PRODUCT_SPAN) return WORD_MAX;
		return clamp_word(longint'(prod) + longint'(origin));
	endfunction

	// burning ship iteration count for one pixel request
	function automatic logic [ITER_BITS-1:0] escape_count(input pixel_t p);
		longint      cr, ci, nr, ni;
		logic [63:0] ar, ai, rr, ii, xx;
		logic [64:0] norm;
		int unsigned n;
		bit          done;
		cr = plane_point(p.pixel_x, plane_re);
		ci = plane_point(p.pixel_y, plane_im);
		ar = magnitude(cr);
		ai = magnitude(ci);
		n = 1;
		done = 1'b0;
		while (!done) begin
			rr = ar * ar;
			ii = ai * ai;
			norm = {1'b0, rr} + {1'b0, ii};
			if (norm >= ESCAPE_NORM || n >= iter_limit) begin
				done = 1'b1;
			end else begin
				xx = ar * ai;
				nr = longint'(rr >> FRAC_BITS) - longint'(ii >> FRAC_BITS) + cr;
				ni = longint'(xx >> (FRAC_BITS - 1)) + ci;
				ar = magnitude(clamp_word(nr));
				ai = magnitude(clamp_word(ni));
				n++;
			end
		end
		return n[ITER_BITS-1:0];
	endfunction

	// compare one accepted result request with the oldest prediction
	task automatic check_result(input result_t got);
		result_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result, expected none, got x=%0d y=%0d count=%0d",
				$time, got.out_x, got.out_y, got.iteration_count);
		end else begin
			want = pending_results.pop_front();
			if (want.out_x !== got.out_x || want.out_y !== got.out_y ||
					want.iteration_count !== got.iteration_count) begin
				mismatches++;
				$display("%0t: expected x=%0d y=%0d count=%0d, got x=%0d y=%0d count=%0d",
					$time, want.out_x, want.out_y, want.iteration_count,
					got.out_x, got.out_y, got.iteration_count);
			end
		end
	endtask

	// result side: check each accepted request, then pick the next stall value
	initial begin
		int hold_left;
		int rx_burst;
		hold_left = 0;
		rx_burst = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall)
				check_result(res);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (rx_burst > 0) begin
				rx_burst--;
				res_stall <= 1'b1;
			end else if (rx_idle && $urandom_range(0, 9) == 0) begin
				rx_burst = $urandom_range(1, 19) - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// offer one pixel request, predict its result once it is taken
	task automatic send_pixel(input int x, input int y);
		pixel_t  p;
		result_t e;
		p.pixel_x = COORD_BITS'(x);
		p.pixel_y = COORD_BITS'(y);
		pix <= p;
		pix_valid <= 1'b1;
		do @(posedge clk); while (pix_stall);
		e.out_x = p.pixel_x;
		e.out_y = p.pixel_y;
		e.iteration_count = escape_count(p);
		pending_results.push_back(e);
		pixels_sent++;
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// stop offering and wait until every prediction is matched
	task automatic drain_results();
		pix_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write request, leaves valid up for a following write
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [WORD_BITS-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_STEP:        plane_step = data[STEP_BITS-1:0];
			REG_REAL_ORIGIN: plane_re = data;
			REG_IMAG_ORIGIN: plane_im = data;
			REG_ITER_LIMIT:  iter_limit = data[ITER_BITS-1:0];
			default: ;
		endcase
		config_writes++;
	endtask

	// program all four registers while the unit is idle
	task automatic configure(input logic [WORD_BITS-1:0] step_w, input logic [WORD_BITS-1:0] re_w,
			input logic [WORD_BITS-1:0] im_w, input logic [WORD_BITS-1:0] lim_w);
		write_reg(REG_STEP, step_w);
		write_reg(REG_REAL_ORIGIN, re_w);
		write_reg(REG_IMAG_ORIGIN, im_w);
		write_reg(REG_ITER_LIMIT, lim_w);
		cfg_valid <= 1'b0;
	endtask

	// register values straight out of reset, two corners and two inner points of the frame
	task automatic test_reset_values();
		send_pixel(0, 0);
		send_pixel(PIX_MAX, PIX_MAX);
		send_pixel(1500, 1100);
		send_pixel(750, 550);
		drain_results();
	endtask

	// limit of zero, one and the maximum on a point that never escapes
	task automatic test_iteration_limits();
		configure(32'h0, 32'h0, 32'h0, 32'hFFFF_0000);
		send_pixel(5, 5);
		drain_results();
		configure(32'h0, 32'h0, 32'h0, 32'h5A5A_0001);
		send_pixel(0, 0);
		drain_results();
		configure(32'h0, 32'h0, 32'h0, 32'hABCD_FFFF);
		send_pixel(0, 0);
		drain_results();
	endtask

	// plane coordinates pinned at both ends of the word range
	task automatic test_saturation();
		configure(32'hFFFF_FFFF, W_MIN, W_MIN, 32'h0000_0010);
		send_pixel(0, 0);
		send_pixel(1, 1);
		send_pixel(2, 2);
		send_pixel(PIX_MAX, 0);
		send_pixel(0, PIX_MAX);
		drain_results();
		configure(32'h1, W_MAX, W_MAX, 32'h0000_0064);
		send_pixel(PIX_MAX, PIX_MAX);
		send_pixel(0, 0);
		drain_results();
	endtask

	// magnitude exactly on and just inside the escape circle
	task automatic test_escape_boundary();
		configure(32'h0, W_TWO, 32'h0, 32'h0000_0032);
		send_pixel(0, 0);
		send_pixel(PIX_MAX, PIX_MAX);
		drain_results();
		configure(32'h0, W_TWO - 1, 32'h0, 32'h0000_0032);
		send_pixel(3, 3);
		drain_results();
	endtask

	// receiver holds off while requests keep coming, so the queue fills
	task automatic test_backpressure();
		int k;
		configure(32'd223696, 32'hE000_0000, 32'hE000_0000, 32'h0000_0020);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_request = LONG_HOLD;
		for (k = 0; k < 24; k++)
			send_pixel($urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX));
		drain_results();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// random plane windows over the ship, some fully random register words
	task automatic test_random_windows();
		int                   ph, k, n_items;
		bit                   slow;
		logic [WORD_BITS-1:0] s_w, re_w, im_w, l_w;
		logic [ITER_BITS-1:0] lim;
		for (ph = 0; ph < 16; ph++) begin
			slow = (ph % 5 == 4);
			lim = slow ? ITER_BITS'($urandom_range(129, 400))
			           : ITER_BITS'($urandom_range(1, 128));
			if ($urandom_range(0, 4) == 0) begin
				s_w = $urandom;
				re_w = $urandom;
				im_w = $urandom;
			end else begin
				s_w = $urandom_range(2000, 600000);
				re_w = $urandom_range(0, 805306368) - 671088640;
				im_w = $urandom_range(0, 671088640) - 536870912;
				s_w[WORD_BITS-1] = 1'($urandom_range(0, 1));
			end
			l_w = $urandom;
			l_w[ITER_BITS-1:0] = lim;
			configure(s_w, re_w, im_w, l_w);
			// the closing phases run with no idling on either side
			tx_idle = (ph < 13) && ($urandom_range(0, 3) != 0);
			rx_idle = (ph < 13) && ($urandom_range(0, 3) != 0);
			n_items = slow ? 30 : 130;
			for (k = 0; k < n_items; k++)
				send_pixel($urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX));
			drain_results();
		end
	endtask

	// reset once, then the tests in turn
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_iteration_limits();
		test_saturation();
		test_escape_boundary();
		test_backpressure();
		test_random_windows();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d pixel requests and %0d register writes", pixels_sent,
			config_writes);
		$display("limits 0/1/max, saturated planes, escape edge, long result hold; %0d checked",
			results_seen);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#(48_000_000);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
